// File: rtl/tx_stream_field_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the transaction parser checker.
// ----------------------------------------------------------------------------
`ifndef TX_STREAM_FIELD_PARSER_ASSERT_SVH
`define TX_STREAM_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSFP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tsfp_pkg.sv
// ----------------------------------------------------------------------------
// tsfp_pkg
// Types, field codes and helpers of the transaction field parser.
// ----------------------------------------------------------------------------
package tsfp_pkg;

   // Parse phases; each code equals the field kind reported for it.
   typedef enum logic [3:0] {
      PH_VERSION    = 4'd0,
      PH_INCOUNT    = 4'd1,
      PH_HASH       = 4'd2,
      PH_PREVIDX    = 4'd3,
      PH_INSCRLEN   = 4'd4,
      PH_INSCRBYTE  = 4'd5,
      PH_SEQ        = 4'd6,
      PH_OUTCOUNT   = 4'd7,
      PH_VALUE      = 4'd8,
      PH_OUTSCRLEN  = 4'd9,
      PH_OUTSCRBYTE = 4'd10,
      PH_LOCKTIME   = 4'd11
   } phase_type;

   localparam logic [7:0] VarintPfx16 = 8'hfd;
   localparam logic [7:0] VarintPfx32 = 8'hfe;
   localparam logic [5:0] HashBytes   = 6'd32;

   // One result token as it leaves the parse core.
   typedef struct packed {
      logic        hit;
      phase_type   kind;
      logic [63:0] value;
      logic [63:0] entry;
      logic [63:0] pos;
      logic        tx_end;
   } tok_type;

   // Bytes a phase starts with: the fixed width, one for a varint's first byte, zero for byte phases.
   function automatic logic [5:0] field_len(input phase_type p);
      logic [5:0] len;
      unique case (p) inside
         PH_VALUE:                                    len = 6'd8;
         PH_HASH:                                     len = HashBytes;
         PH_VERSION, PH_PREVIDX, PH_SEQ, PH_LOCKTIME: len = 6'd4;
         PH_INCOUNT, PH_INSCRLEN, PH_OUTCOUNT, PH_OUTSCRLEN: len = 6'd1;
         default:                                     len = 6'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/tx_stream_field_parser.sv
// ----------------------------------------------------------------------------
// tx_stream_field_parser: legacy transaction field parser, one byte a beat.
// Result path: a byte passes the input register, then the result register.
// Throughput: one byte per cycle while the result stream is not stalled.
// Reset (synchronous): parser returns to the version field, registers empty.
// ----------------------------------------------------------------------------
module tx_stream_field_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_kind,
   output logic [63:0] rsp_field_value,
   output logic [63:0] rsp_entry_number,
   output logic [63:0] rsp_byte_position,
   output logic        rsp_tx_end
);
   import tsfp_pkg::*;

   // The design is three registered sections. The input register captures
   // each stream beat. The parse core consumes the held byte in a single step:
   // it shifts the byte into the field assembly, walks the phase machine
   // (version, input count, inputs, output count, outputs, locktime) and
   // produces at most one token. The result register holds that token until
   // the consumer takes the beat. While a finished result waits under a
   // stall, the core pauses and the input register holds at most one more
   // byte, after which the input channel is stalled as well.

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       step;
   tok_type    tok;

   // A held byte is consumed only when the result register can take
   // whatever it produces. Bytes in the middle of a field produce nothing,
   // but they wait for the same slot to keep the ordering simple.
   assign step = byte_valid && out_free;

   tsfp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .take          (step),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data)
   );

   // Counts, lengths and positions are kept at the full 64 bits, so huge
   // counts or script lengths are parsed exactly as the stream states them.
   tsfp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (byte_data),
      .tok       (tok)
   );

   tsfp_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .tok               (tok),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_field_value   (rsp_field_value),
      .rsp_entry_number  (rsp_entry_number),
      .rsp_byte_position (rsp_byte_position),
      .rsp_tx_end        (rsp_tx_end)
   );

endmodule

// File: rtl/tsfp_in_reg.sv
// ----------------------------------------------------------------------------
// tsfp_in_reg
// Input register: holds one stream byte until the parse core takes it.
// ----------------------------------------------------------------------------
module tsfp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import tsfp_pkg::*;

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;

   // The register can refill whenever it is empty or its byte leaves now.
   assign req_stall = vld_ff && !take;
   assign vld_in    = req_stall ? vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         byte_ff <= req_data_byte;
      end
   end

   assign byte_valid = vld_ff;
   assign byte_data  = byte_ff;

endmodule

// File: rtl/tsfp_parse_core.sv
// ----------------------------------------------------------------------------
// tsfp_parse_core
// Phase machine and field assembly; one byte is consumed per step.
// ----------------------------------------------------------------------------
module tsfp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   output tsfp_pkg::tok_type    tok
);
   import tsfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [5:0]  fbl_ff, fbl_in;
   logic [5:0]  fbi_ff, fbi_in;
   logic [63:0] asm_ff, asm_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] ec_ff, ec_in;
   logic [63:0] sbl_ff, sbl_in;
   logic [63:0] sp_ff, sp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION;
         pend_ff  <= 1'b0;
         fbl_ff   <= field_len(PH_VERSION);
         fbi_ff   <= '0;
         asm_ff   <= '0;
         total_ff <= '0;
         ec_ff    <= '0;
         sbl_ff   <= '0;
         sp_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         fbl_ff   <= fbl_in;
         fbi_ff   <= fbi_in;
         asm_ff   <= asm_in;
         total_ff <= total_in;
         ec_ff    <= ec_in;
         sbl_ff   <= sbl_in;
         sp_ff    <= sp_in;
      end
   end

   logic [63:0] asm_take;
   logic [5:0]  fbi_inc;
   logic [5:0]  fbl_dec;
   logic [63:0] ec_inc;
   logic        ec_last;
   logic        enter_req;
   phase_type   enter_ph;
   logic        done;
   logic [63:0] value;
   logic [63:0] entry;
   logic [63:0] pos;
   logic        tend;

   // Byte shifted into the little-endian assembly register.
   assign asm_take = asm_ff | (64'(data_byte) << {fbi_ff[2:0], 3'b000});
   assign fbi_inc  = fbi_ff + 6'd1;
   assign fbl_dec  = (fbl_ff != 6'd0) ? fbl_ff - 6'd1 : 6'd0;
   assign ec_inc   = ec_ff + 64'd1;
   assign ec_last  = (ec_inc == total_ff);

   always_comb begin
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      fbl_in    = fbl_ff;
      fbi_in    = fbi_ff;
      asm_in    = asm_ff;
      total_in  = total_ff;
      ec_in     = ec_ff;
      sbl_in    = sbl_ff;
      sp_in     = sp_ff;
      enter_req = 1'b0;
      enter_ph  = PH_VERSION;
      done      = 1'b0;
      value     = '0;
      entry     = '0;
      pos       = '0;
      tend      = 1'b0;

      unique case (phase_ff) inside
         PH_HASH: begin
            value  = 64'(data_byte);
            pos    = 64'(fbi_ff);
            entry  = ec_ff;
            done   = 1'b1;
            fbi_in = fbi_inc;
            if (fbi_inc >= HashBytes) begin
               enter_req = 1'b1;
               enter_ph  = PH_PREVIDX;
            end
         end
         PH_INSCRBYTE, PH_OUTSCRBYTE: begin
            value  = 64'(data_byte);
            pos    = sp_ff;
            entry  = ec_ff;
            done   = 1'b1;
            sp_in  = sp_ff + 64'd1;
            sbl_in = sbl_ff - 64'd1;
            if (sbl_ff == 64'd1) begin
               enter_req = 1'b1;
               if (phase_ff == PH_INSCRBYTE) begin
                  enter_ph = PH_SEQ;
               end else begin
                  ec_in    = ec_inc;
                  enter_ph = ec_last ? PH_LOCKTIME : PH_VALUE;
               end
            end
         end
         PH_INCOUNT, PH_INSCRLEN, PH_OUTCOUNT, PH_OUTSCRLEN: begin
            if (!pend_ff) begin
               if (data_byte < VarintPfx16) begin
                  value = 64'(data_byte);
                  done  = 1'b1;
               end else begin
                  // Prefix byte: 2, 4 or 8 little-endian bytes follow.
                  pend_in = 1'b1;
                  fbl_in  = (data_byte == VarintPfx16) ? 6'd2 :
                            (data_byte == VarintPfx32) ? 6'd4 : 6'd8;
                  fbi_in  = '0;
                  asm_in  = '0;
               end
            end else begin
               asm_in = asm_take;
               fbi_in = fbi_inc;
               fbl_in = fbl_dec;
               if (fbl_dec == 6'd0) begin
                  value = asm_take;
                  done  = 1'b1;
               end
            end
            if (done) begin
               enter_req = 1'b1;
               if (phase_ff == PH_INCOUNT || phase_ff == PH_OUTCOUNT) begin
                  total_in = value;
                  ec_in    = '0;
                  if (phase_ff == PH_INCOUNT) begin
                     enter_ph = (value == 64'd0) ? PH_OUTCOUNT : PH_HASH;
                  end else begin
                     enter_ph = (value == 64'd0) ? PH_LOCKTIME : PH_VALUE;
                  end
               end else begin
                  entry  = ec_ff;
                  sbl_in = value;
                  sp_in  = '0;
                  if (phase_ff == PH_INSCRLEN) begin
                     enter_ph = (value == 64'd0) ? PH_SEQ : PH_INSCRBYTE;
                  end else if (value == 64'd0) begin
                     ec_in    = ec_inc;
                     enter_ph = ec_last ? PH_LOCKTIME : PH_VALUE;
                  end else begin
                     enter_ph = PH_OUTSCRBYTE;
                  end
               end
            end
         end
         PH_VERSION, PH_PREVIDX, PH_SEQ, PH_VALUE, PH_LOCKTIME: begin
            asm_in = asm_take;
            fbi_in = fbi_inc;
            fbl_in = fbl_dec;
            if (fbl_dec == 6'd0) begin
               value     = asm_take;
               done      = 1'b1;
               enter_req = 1'b1;
               unique case (phase_ff) inside
                  PH_VERSION: begin
                     enter_ph = PH_INCOUNT;
                  end
                  PH_PREVIDX: begin
                     entry    = ec_ff;
                     enter_ph = PH_INSCRLEN;
                  end
                  PH_SEQ: begin
                     entry    = ec_ff;
                     ec_in    = ec_inc;
                     enter_ph = ec_last ? PH_OUTCOUNT : PH_HASH;
                  end
                  PH_VALUE: begin
                     entry    = ec_ff;
                     enter_ph = PH_OUTSCRLEN;
                  end
                  default: begin
                     tend     = 1'b1;
                     enter_ph = PH_VERSION;
                  end
               endcase
            end
         end
         default: begin
            enter_req = 1'b1;
            enter_ph  = PH_VERSION;
         end
      endcase

      // Entering a phase clears the field assembly.
      if (enter_req) begin
         phase_in = enter_ph;
         pend_in  = 1'b0;
         fbi_in   = '0;
         asm_in   = '0;
         fbl_in   = field_len(enter_ph);
      end
   end

   always_comb begin
      tok.hit    = step && done;
      tok.kind   = phase_ff;
      tok.value  = value;
      tok.entry  = entry;
      tok.pos    = pos;
      tok.tx_end = tend;
   end

endmodule

// File: rtl/tsfp_rsp_reg.sv
// ----------------------------------------------------------------------------
// tsfp_rsp_reg
// Result register: holds one token until the consumer takes the beat.
// ----------------------------------------------------------------------------
module tsfp_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  tsfp_pkg::tok_type tok,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_field_kind,
   output logic [63:0]       rsp_field_value,
   output logic [63:0]       rsp_entry_number,
   output logic [63:0]       rsp_byte_position,
   output logic              rsp_tx_end
);
   import tsfp_pkg::*;

   logic    vld_ff, vld_in;
   tok_type tok_ff;

   assign free   = !vld_ff || !rsp_stall;
   assign vld_in = free ? tok.hit : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && tok.hit) begin
         tok_ff <= tok;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_field_kind    = tok_ff.kind;
   assign rsp_field_value   = tok_ff.value;
   assign rsp_entry_number  = tok_ff.entry;
   assign rsp_byte_position = tok_ff.pos;
   assign rsp_tx_end        = tok_ff.tx_end;

endmodule

// File: rtl/tsfp_checker.sv
// ----------------------------------------------------------------------------
// tsfp_checker
// Port-level checks of the transaction parser result stream.
// ----------------------------------------------------------------------------
`include "tx_stream_field_parser_assert.svh"

module tsfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_field_kind,
   input logic [63:0] rsp_field_value,
   input logic [63:0] rsp_byte_position,
   input logic        rsp_tx_end
);
   import tsfp_pkg::*;

   logic byte_kind;
   logic hash_kind;

   assign hash_kind = (rsp_field_kind == PH_HASH);
   assign byte_kind = hash_kind || (rsp_field_kind == PH_INSCRBYTE) ||
                      (rsp_field_kind == PH_OUTSCRBYTE);

   // Only the locktime beat closes a transaction, and it always does.
   `TSFP_ASSERT_NOW(a_tx_end_kind, clock, reset, rsp_valid, rsp_tx_end == (rsp_field_kind == PH_LOCKTIME), "tx_end does not match the locktime kind")

   // Hash and script beats carry a single byte.
   `TSFP_ASSERT_NOW(a_byte_value, clock, reset, rsp_valid && byte_kind, rsp_field_value[63:8] == 56'd0, "byte kind carries more than one byte")

   // Hash positions stay inside the hash; fields that are not byte kinds
   // report position zero.
   `TSFP_ASSERT_NOW(a_position, clock, reset, rsp_valid, byte_kind ? (!hash_kind || rsp_byte_position < 64'd32) : (rsp_byte_position == 64'd0), "byte position out of range")

   // A stalled result beat is held.
   `TSFP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_field_kind) && $stable(rsp_field_value), "stalled result beat changed")

endmodule

bind tx_stream_field_parser tsfp_checker u_tsfp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_field_kind    (rsp_field_kind),
   .rsp_field_value   (rsp_field_value),
   .rsp_byte_position (rsp_byte_position),
   .rsp_tx_end        (rsp_tx_end)
);
